// ===== design/halfword_delta_encoder_macros.svh =====
// Assertion macros for the halfword delta encoder top level.
// No dependencies; included by halfword_delta_encoder.sv alone.
`ifndef HALFWORD_DELTA_ENCODER_MACROS_SVH
`define HALFWORD_DELTA_ENCODER_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define HDE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("halfword_delta_encoder: assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define HDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("halfword_delta_encoder: assertion failed");

`endif

// ===== design/hde_pkg.sv =====
// Package for the halfword delta encoder: widths, flag codes and the
// structs passed between the encoder logic and the top level. No dependencies.
package hde_pkg;

	localparam int COUNT_BITS  = 16;
	localparam int VALUE_W     = 16;
	localparam int OFFSET_W    = 18;
	localparam int FLAG_OFF_W  = 15;
	localparam int MAX_RESULTS = 5;
	localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] CODE_ZERO = 2'd0;
	localparam logic [1:0] CODE_BYTE = 2'd1;
	localparam logic [1:0] CODE_WORD = 2'd3;

	localparam logic [2:0] GROUP_CODES = 3'd4;

	typedef struct packed {
		logic                  active;
		logic [7:0]            flag_acc;
		logic [2:0]            codes_left;
		logic [COUNT_BITS-1:0] pairs_rem;
		logic [FLAG_OFF_W-1:0] flag_off;
		logic [OFFSET_W-1:0]   data_off;
	} hde_state_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [7:0]          value;
		logic                done;
	} hde_entry_t;

	typedef struct packed {
		hde_entry_t [MAX_RESULTS-1:0] entries;
		logic [RES_CNT_W-1:0]         count;
	} hde_result_t;

endpackage

// ===== design/hde_pair_encode.sv =====
// Combinational encoder for one halfword pair: next block state and the
// ordered list of byte writes it causes. Depends on hde_pkg.
module hde_pair_encode (
	input  hde_pkg::hde_state_t  cur,
	input  logic [15:0]          element_count,
	input  logic [15:0]          first_value,
	input  logic [15:0]          second_value,
	output hde_pkg::hde_state_t  nxt,
	output hde_pkg::hde_result_t res
);
	import hde_pkg::*;

	hde_state_t            st;
	logic [COUNT_BITS-1:0] count;
	logic [16:0]           count_pad;
	logic [15:0]           diff;
	logic [15:0]           biased;
	logic [1:0]            code;
	logic [1:0]            left;
	logic [7:0]            flag_byte;
	logic [7:0]            total;
	logic [RES_CNT_W-1:0]  n;

	assign count     = element_count[COUNT_BITS-1:0];
	assign count_pad = 17'(count) + 17'd7;
	assign diff      = first_value - second_value;
	assign biased    = diff + 16'h0080;

	always_comb begin
		if (diff == 16'd0) begin
			code = CODE_ZERO;
		end else if (biased < 16'h0100) begin
			code = CODE_BYTE;
		end else begin
			code = CODE_WORD;
		end
	end

	always_comb begin
		// A new block loads its counters when the first pair arrives.
		st = cur;
		if (!cur.active) begin
			st.active     = 1'b1;
			st.flag_acc   = 8'd0;
			st.codes_left = GROUP_CODES;
			st.pairs_rem  = count;
			st.flag_off   = FLAG_OFF_W'(1);
			st.data_off   = OFFSET_W'(count_pad[16:2]);
		end

		nxt       = st;
		res       = '0;
		n         = '0;
		left      = 2'd0;
		flag_byte = 8'd0;
		total     = 8'd0;

		nxt.flag_acc = {st.flag_acc[5:0], code};

		if (code != CODE_ZERO) begin
			res.entries[n[RES_IDX_W-1:0]] = '{offset: nxt.data_off, value: diff[7:0], done: 1'b0};
			n            = n + 1'b1;
			nxt.data_off = nxt.data_off + 1'b1;
		end
		if (code == CODE_WORD) begin
			res.entries[n[RES_IDX_W-1:0]] = '{offset: nxt.data_off, value: diff[15:8], done: 1'b0};
			n            = n + 1'b1;
			nxt.data_off = nxt.data_off + 1'b1;
		end

		nxt.pairs_rem = st.pairs_rem - 1'b1;
		if (nxt.pairs_rem != '0) begin
			nxt.codes_left = st.codes_left - 1'b1;
			if (nxt.codes_left == 3'd0) begin
				res.entries[n[RES_IDX_W-1:0]] =
					'{offset: OFFSET_W'(st.flag_off), value: nxt.flag_acc, done: 1'b0};
				n              = n + 1'b1;
				nxt.flag_off   = st.flag_off + 1'b1;
				nxt.flag_acc   = 8'd0;
				nxt.codes_left = GROUP_CODES;
			end
		end else begin
			// End of block: left-align the partial flag byte, then write the
			// length byte to the header and to the trailer.
			left      = 2'(st.codes_left - 1'b1);
			flag_byte = nxt.flag_acc << {left, 1'b0};
			total     = nxt.data_off[7:0] + 8'd1;
			res.entries[n[RES_IDX_W-1:0]] =
				'{offset: OFFSET_W'(st.flag_off), value: flag_byte, done: 1'b0};
			n = n + 1'b1;
			res.entries[n[RES_IDX_W-1:0]] = '{offset: '0, value: total, done: 1'b0};
			n = n + 1'b1;
			res.entries[n[RES_IDX_W-1:0]] = '{offset: nxt.data_off, value: total, done: 1'b1};
			n = n + 1'b1;
			nxt.active = 1'b0;
		end
		res.count = n;
	end

endmodule

// ===== design/halfword_delta_encoder.sv =====
// Top level of the halfword delta encoder: handshakes, block state, the
// result list stage and the output register. Depends on hde_pkg,
// hde_pair_encode and halfword_delta_encoder_macros.svh.
//
//  channel   direction  handshake            payload
//  config    in         element_count_we     element_count
//  input     in         in_valid / in_stall  first_value, second_value
//  output    out        out_valid/out_stall  byte_offset, byte_value, last_of_run, block_done
//
// A pair is encoded in the cycle it is accepted; its zero to five byte writes wait in the
// result stage and leave through the output register one per cycle while the output does
// not stall: zero to three in steady state, three to five at the end of a block.
// The next pair is accepted in the cycle the last byte moves to the output register.
// Reset clears the block state and all valid flags and sets element_count to one.
// An output stall holds the output register and, while the result stage is busy, the input.
`include "halfword_delta_encoder_macros.svh"

module halfword_delta_encoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           element_count_we,
	input  logic [15:0]                    element_count,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [15:0]                    first_value,
	input  logic [15:0]                    second_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [hde_pkg::OFFSET_W-1:0]   byte_offset,
	output logic [7:0]                     byte_value,
	output logic                           last_of_run,
	output logic                           block_done
);
	import hde_pkg::*;

	// Block state and the sampled register value.
	hde_state_t  state_q;
	hde_state_t  state_nxt;
	logic [15:0] element_count_q;

	// Result stage: the byte writes of one pair and a read pointer.
	hde_result_t          res_nxt;
	hde_result_t          res_s1;
	logic                 valid_s1;
	logic [RES_IDX_W-1:0] idx_s1;

	// Output register.
	logic                 out_valid_q;
	logic [OFFSET_W-1:0]  byte_offset_q;
	logic [7:0]           byte_value_q;
	logic                 last_of_run_q;
	logic                 block_done_q;

	logic       out_free;
	logic       s1_move;
	logic       s1_last;
	logic       in_acc;
	hde_entry_t head;

	hde_pair_encode u_encode (
		.cur           (state_q),
		.element_count (element_count_q),
		.first_value   (first_value),
		.second_value  (second_value),
		.nxt           (state_nxt),
		.res           (res_nxt)
	);

	// The output register can take a byte when it is empty or being taken.
	assign out_free = !out_valid_q || !out_stall;
	assign s1_move  = valid_s1 && out_free;
	assign s1_last  = (RES_CNT_W'(idx_s1) == res_s1.count - 1'b1);
	assign head     = res_s1.entries[idx_s1];

	// The stage frees up in the cycle its last byte leaves.
	assign in_stall = valid_s1 && !(s1_move && s1_last);
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= 16'd1;
			state_q         <= '{active: 1'b0, flag_acc: 8'd0, codes_left: GROUP_CODES,
			                     pairs_rem: COUNT_BITS'(1), flag_off: FLAG_OFF_W'(1),
			                     data_off: OFFSET_W'(2)};
			valid_s1        <= 1'b0;
			idx_s1          <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (element_count_we) begin
				element_count_q <= element_count;
			end
			if (in_acc) begin
				state_q <= state_nxt;
			end
			// A pair with no byte writes never enters the result stage.
			if (in_acc) begin
				valid_s1 <= (res_nxt.count != '0);
				idx_s1   <= '0;
			end else if (s1_move && s1_last) begin
				valid_s1 <= 1'b0;
			end else if (s1_move) begin
				idx_s1 <= idx_s1 + 1'b1;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_s1 <= res_nxt;
		end
		if (s1_move) begin
			byte_offset_q <= head.offset;
			byte_value_q  <= head.value;
			last_of_run_q <= s1_last;
			block_done_q  <= head.done;
		end
	end

	assign out_valid   = out_valid_q;
	assign byte_offset = byte_offset_q;
	assign byte_value  = byte_value_q;
	assign last_of_run = last_of_run_q;
	assign block_done  = block_done_q;

	// The read pointer stays inside the list held by the result stage.
	`HDE_ASSERT_NOW(a_idx_in_list, clk, arst_n, valid_s1, RES_CNT_W'(idx_s1) < res_s1.count)
	// The trailer byte is always the last byte of its pair.
	`HDE_ASSERT_NOW(a_done_is_last, clk, arst_n, out_valid_q && block_done_q, last_of_run_q)
	// A pair that ends its block leaves the block inactive.
	`HDE_ASSERT_NEXT(a_block_closes, clk, arst_n, in_acc && state_nxt.pairs_rem == '0,
		!state_q.active)

endmodule

// ===== dv/halfword_delta_encoder_tb.sv =====
// Self-checking testbench for halfword_delta_encoder: random and directed pairs,
// every byte write checked against an in-bench encoder. Depends on hde_pkg and
// the halfword_delta_encoder RTL.
module halfword_delta_encoder_tb;

	// Handshake timing: the bench drives on the falling edge and samples on the
	// rising edge, so every sampled value settled half a period earlier.
	localparam int SETTLE_CYCLES   = 8;     // quiet time before a count write or the end
	localparam int HOLD_CYCLES     = 200;   // long receiver hold-off for back-pressure
	localparam int WATCHDOG_LIMIT  = 1000;  // cycles without any transaction
	localparam int RANDOM_PAIRS    = 190;
	localparam int DRAIN_CYCLES    = 17;    // lets an idle burst already running run out

	typedef enum {KIND_ZERO, KIND_BYTE, KIND_WORD, KIND_ANY} pair_kind_t;

	typedef struct packed {
		logic [15:0] minuend;
		logic [15:0] subtrahend;
	} hw_pair_t;

	typedef struct packed {
		logic [hde_pkg::OFFSET_W-1:0] offset;
		logic [7:0]                   value;
		logic                         last_of_run;
		logic                         block_done;
	} byte_write_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [15:0]                  cfg_count;
	logic                         in_valid;
	logic                         in_stall;
	logic [15:0]                  first_value;
	logic [15:0]                  second_value;
	logic                         out_valid;
	logic                         out_stall;
	logic [hde_pkg::OFFSET_W-1:0] byte_offset;
	logic [7:0]                   byte_value;
	logic                         last_of_run;
	logic                         block_done;

	halfword_delta_encoder i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.element_count_we (cfg_we),
		.element_count    (cfg_count),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.first_value      (first_value),
		.second_value     (second_value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.byte_offset      (byte_offset),
		.byte_value       (byte_value),
		.last_of_run      (last_of_run),
		.block_done       (block_done)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Pairs waiting to be offered, and byte writes the encoder still owes us.
	hw_pair_t    pair_queue [$];
	byte_write_t byte_queue [$];

	// Encoder state as the bench predicts it. The count is mirrored at the
	// edge where the write lands and sampled only when a block starts.
	logic [15:0]                  model_count;
	logic                         in_block;
	logic [7:0]                   grp_flags;
	logic [2:0]                   grp_codes_left;
	logic [15:0]                  pairs_left;
	logic [hde_pkg::FLAG_OFF_W-1:0] flag_ptr;
	logic [hde_pkg::OFFSET_W-1:0] data_ptr;

	int pairs_pushed;
	int pairs_taken;
	int blocks_done;
	int bytes_checked;
	int error_count;
	int count_writes;
	int backpressure_cycles;
	int quiet_cycles;
	int max_offset_seen;

	// Idle control shared between the stimulus sequence and the two drivers.
	int send_idle_pct;
	int recv_idle_pct;
	int send_gap;
	int stall_left;
	int hold_left;
	logic hold_request;
	logic pair_accepted;
	hw_pair_t next_pair;

	// Encode one accepted pair and queue the byte writes it must produce, in
	// order: data bytes, then a completed flag byte, or at the end of a block
	// the padded flag byte, the header length and the trailer length.
	task automatic encode_pair(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] diff;
		logic [15:0] biased;
		logic [1:0]  code;
		logic [1:0]  pad_codes;
		logic [7:0]  flag_out;
		logic [7:0]  length_byte;
		logic [16:0] sized;
		byte_write_t step_writes [hde_pkg::MAX_RESULTS];
		int n;
		n = 0;
		if (!in_block) begin
			// The data area starts right after a flag area sized for the count,
			// header included; a zero count gives a flag area of nothing.
			sized          = {1'b0, model_count} + 17'd7;
			data_ptr       = hde_pkg::OFFSET_W'(sized >> 2);
			grp_flags      = '0;
			grp_codes_left = hde_pkg::GROUP_CODES;
			pairs_left     = model_count;
			flag_ptr       = hde_pkg::FLAG_OFF_W'(1);
			in_block       = 1'b1;
		end
		diff   = a - b;
		biased = diff + 16'h0080;
		if (diff == 16'h0000) begin
			code = hde_pkg::CODE_ZERO;
		end else if (biased < 16'h0100) begin
			code = hde_pkg::CODE_BYTE;
		end else begin
			code = hde_pkg::CODE_WORD;
		end
		grp_flags = {grp_flags[5:0], code};
		if (code != hde_pkg::CODE_ZERO) begin
			step_writes[n] = '{data_ptr, diff[7:0], 1'b0, 1'b0};
			n++;
			data_ptr++;
		end
		if (code == hde_pkg::CODE_WORD) begin
			step_writes[n] = '{data_ptr, diff[15:8], 1'b0, 1'b0};
			n++;
			data_ptr++;
		end
		// The pair counter wraps, so a zero count runs a full 2^16 pairs.
		pairs_left--;
		if (pairs_left != 16'd0) begin
			grp_codes_left--;
			if (grp_codes_left == 3'd0) begin
				step_writes[n] = '{{3'b000, flag_ptr}, grp_flags, 1'b0, 1'b0};
				n++;
				flag_ptr++;
				grp_flags      = '0;
				grp_codes_left = hde_pkg::GROUP_CODES;
			end
		end else begin
			// A partial group is shifted up so that its first code sits on top.
			pad_codes      = 2'(grp_codes_left - 3'd1);
			flag_out       = grp_flags << {pad_codes, 1'b0};
			length_byte    = 8'(data_ptr + 1'b1);
			step_writes[n] = '{{3'b000, flag_ptr}, flag_out, 1'b0, 1'b0};
			n++;
			step_writes[n] = '{'0, length_byte, 1'b0, 1'b0};
			n++;
			step_writes[n] = '{data_ptr, length_byte, 1'b0, 1'b1};
			n++;
			in_block = 1'b0;
			blocks_done++;
		end
		for (int i = 0; i < n; i++) begin
			if (i == n - 1) begin
				step_writes[i].last_of_run = 1'b1;
			end
			byte_queue.push_back(step_writes[i]);
		end
	endtask

	function automatic void compare_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field,
				want, got);
		end
	endfunction

	task automatic check_byte();
		byte_write_t want;
		if (byte_queue.size() == 0) begin
			error_count++;
			$display("%0t: unexpected byte write, expected none, actual 0x%0h at 0x%0h",
				$time, byte_value, byte_offset);
		end else begin
			want = byte_queue.pop_front();
			compare_field("byte_offset", want.offset, byte_offset);
			compare_field("byte_value", want.value, byte_value);
			compare_field("last_of_run", want.last_of_run, last_of_run);
			compare_field("block_done", want.block_done, block_done);
			bytes_checked++;
			if (int'(byte_offset) > max_offset_seen) begin
				max_offset_seen = int'(byte_offset);
			end
		end
	endtask

	// Rising edge: everything the bench observes. The output side is checked
	// before a new pair is encoded, since a pair taken at this edge cannot yet
	// have a byte on the output register.
	always @(posedge clk) begin
		pair_accepted = 1'b0;
		if (arst_n) begin
			if (cfg_we) begin
				model_count = cfg_count;
			end
			if (out_valid && !out_stall) begin
				check_byte();
			end
			if (in_valid && !in_stall) begin
				encode_pair(first_value, second_value);
				pair_accepted = 1'b1;
				pairs_taken++;
			end
			if (in_valid && in_stall) begin
				backpressure_cycles++;
			end
			if (pair_accepted || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d byte writes outstanding",
					$time, quiet_cycles, byte_queue.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Sender: a transaction stays on the bus, payload unchanged, until it is
	// taken. Between transactions it may go quiet for a randomly drawn burst.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || pair_accepted) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pair_queue.size() != 0 && send_idle_pct != 0
					&& $urandom_range(0, 99) < send_idle_pct) begin
				send_gap = $urandom_range(1, 17) - 1;
				in_valid <= 1'b0;
			end else if (pair_queue.size() != 0) begin
				next_pair = pair_queue.pop_front();
				first_value  <= next_pair.minuend;
				second_value <= next_pair.subtrahend;
				in_valid     <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request that is
	// timed here so the sender keeps offering pairs while the encoder fills up.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_CYCLES;
		end
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
			stall_left = $urandom_range(1, 17) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic push_pair(input logic [15:0] a, input logic [15:0] b);
		pair_queue.push_back('{a, b});
		pairs_pushed++;
	endtask

	// Builds a pair whose difference falls in the requested size class; the
	// second value is always fully random so that every input bit toggles.
	task automatic push_random_pair(input pair_kind_t kind);
		logic [15:0] base;
		logic [15:0] delta;
		int k;
		base = 16'($urandom);
		case (kind)
			KIND_ZERO: begin
				delta = 16'h0000;
			end
			KIND_BYTE: begin
				// -128..-1 and 1..127
				k = $urandom_range(0, 254);
				delta = (k < 128) ? 16'(16'hFFFF - k) : 16'(k - 127);
			end
			KIND_WORD: begin
				delta = 16'($urandom_range(16'h0080, 16'hFF7F));
			end
			default: begin
				delta = 16'($urandom) - base;
			end
		endcase
		push_pair(base + delta, base);
	endtask

	function automatic pair_kind_t pick_kind(input int zero_pct, input int byte_pct,
			input int word_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < zero_pct) begin
			return KIND_ZERO;
		end else if (r < zero_pct + byte_pct) begin
			return KIND_BYTE;
		end else if (r < zero_pct + byte_pct + word_pct) begin
			return KIND_WORD;
		end
		return KIND_ANY;
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 2))
			0: begin
				return 0;
			end
			1: begin
				return 10;
			end
			default: begin
				return 35;
			end
		endcase
	endfunction

	// Waits until every pushed pair was taken and every owed byte arrived, then
	// gives a code-zero pair that owes nothing time to leave the encoder.
	task automatic wait_idle();
		while (pairs_taken != pairs_pushed || byte_queue.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_count <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		count_writes++;
	endtask

	initial begin
		int random_pairs;
		int n_pairs;
		int count_pick;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_count           = 16'd1;
		in_valid            = 1'b0;
		first_value         = 16'h0000;
		second_value        = 16'h0000;
		out_stall           = 1'b0;
		hold_request        = 1'b0;
		send_idle_pct       = 0;
		recv_idle_pct       = 0;
		send_gap            = 0;
		stall_left          = 0;
		hold_left           = 0;
		pair_accepted       = 1'b0;
		model_count         = 16'd1;
		in_block            = 1'b0;
		grp_flags           = '0;
		grp_codes_left      = hde_pkg::GROUP_CODES;
		pairs_left          = 16'd1;
		flag_ptr            = hde_pkg::FLAG_OFF_W'(1);
		data_ptr            = hde_pkg::OFFSET_W'(2);
		pairs_pushed        = 0;
		pairs_taken         = 0;
		blocks_done         = 0;
		bytes_checked       = 0;
		error_count         = 0;
		count_writes        = 0;
		backpressure_cycles = 0;
		quiet_cycles        = 0;
		max_offset_seen     = 0;
		random_pairs        = 0;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. The reset count of one makes each pair a block of its
		// own: equal values, a difference of -1, and the first word-sized delta.
		push_pair(16'h0000, 16'h0000);
		push_pair(16'hFFFF, 16'h0000);
		push_pair(16'h0080, 16'h0000);
		wait_idle();
		// A block that fills exactly one group: both byte limits, the first
		// negative word delta, and equal all-ones values.
		write_count(16'd4);
		push_pair(16'h007F, 16'h0000);
		push_pair(16'h0000, 16'h0080);
		push_pair(16'h0000, 16'h0081);
		push_pair(16'hFFFF, 16'hFFFF);
		wait_idle();
		// Five pairs leave a group of one code that must be padded at the end.
		write_count(16'd5);
		push_pair(16'h8000, 16'h0000);
		push_pair(16'h0000, 16'hFFFF);
		push_pair(16'h7FFF, 16'h8000);
		push_pair(16'h1234, 16'h1234);
		push_pair(16'h0000, 16'h0000);
		wait_idle();
		// A count written while a block is open applies only to the next block:
		// three pairs of a six-pair block, then the new count of two.
		write_count(16'd6);
		repeat (3) push_random_pair(pick_kind(25, 35, 35));
		wait_idle();
		write_count(16'd2);
		repeat (5) push_random_pair(pick_kind(25, 35, 35));
		wait_idle();

		// Back-pressure: a long hold-off on the output while the sender keeps
		// going without gaps, so the encoder has to stall its input.
		write_count(16'd8);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (40) push_random_pair(pick_kind(10, 20, 60));
		hold_request = 1'b1;
		random_pairs += 40;
		wait_idle();

		// Random phases: mostly whole blocks of small counts with random content,
		// some phases stopping inside a block so the next count write lands there.
		while (random_pairs < RANDOM_PAIRS) begin
			case ($urandom_range(0, 9))
				0: begin
					count_pick = 1;
				end
				1: begin
					count_pick = $urandom_range(13, 40);
				end
				default: begin
					count_pick = $urandom_range(2, 12);
				end
			endcase
			write_count(16'(count_pick));
			send_idle_pct = pick_idle_pct();
			recv_idle_pct = pick_idle_pct();
			n_pairs = count_pick * $urandom_range(1, 3);
			if ($urandom_range(0, 9) < 3) begin
				n_pairs += $urandom_range(1, 3);
			end
			if (n_pairs > RANDOM_PAIRS - random_pairs) begin
				n_pairs = RANDOM_PAIRS - random_pairs;
			end
			repeat (n_pairs) push_random_pair(pick_kind(25, 30, 30));
			random_pairs += n_pairs;
			wait_idle();
		end

		// Last part, without idling: let any running idle burst end, close the
		// open block, then two short blocks of unrestricted deltas.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (in_block) begin
			repeat (int'(pairs_left)) push_random_pair(pick_kind(25, 30, 30));
			wait_idle();
		end
		write_count(16'd3);
		repeat (6) push_random_pair(KIND_ANY);
		wait_idle();

		$display("Run covered %0d pairs in %0d blocks over %0d count settings,",
			pairs_taken, blocks_done, count_writes + 1);
		$display("%0d byte writes checked, offsets up to 0x%0h, %0d input stall cycles.",
			bytes_checked, max_offset_seen, backpressure_cycles);
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/hde_pkg.sv
design/hde_pair_encode.sv
design/halfword_delta_encoder.sv
dv/halfword_delta_encoder_tb.sv
